// ===== sv/mtep_pkg.sv =====
// mtep_pkg: beat types, event kind codes and the chunk tag table for the
// midi track event parser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_track;
    } trk_beat_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [3:0]  channel;
        logic [6:0]  note_key;
        logic [6:0]  velocity;
        logic [23:0] tempo_micros;
        logic [31:0] event_tick;
    } evt_beat_t;

    localparam logic [1:0] KIND_NOTE_OFF  = 2'd0;
    localparam logic [1:0] KIND_NOTE_ON   = 2'd1;
    localparam logic [1:0] KIND_SET_TEMPO = 2'd2;
    localparam logic [1:0] KIND_END_TRACK = 2'd3;

    // config register indexes
    localparam logic REG_HEADER_AFTER_END = 1'b0;

    // "MTrk" chunk tag
    function automatic logic [7:0] tag_byte(input logic [1:0] idx);
        logic [7:0] val;
        unique case (idx)
            2'd0: val = 8'h4D;
            2'd1: val = 8'h54;
            2'd2: val = 8'h72;
            default: val = 8'h6B;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mtep_core.sv =====
// mtep_core: parser state registers and the per-byte next-state and event logic.
// Depends on mtep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtep_core #(
    parameter int MAX_VARLEN_BYTES = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire mtep_pkg::trk_beat_t beat,
    input  wire logic               header_after_end,
    output logic                    res_valid,
    output mtep_pkg::evt_beat_t     res
);

    localparam int VLW = 7 * MAX_VARLEN_BYTES;
    localparam logic [2:0] VL_MAX = 3'(MAX_VARLEN_BYTES);

    localparam logic [3:0] PH_HDR_TAG   = 4'd0;
    localparam logic [3:0] PH_HDR_LEN   = 4'd1;
    localparam logic [3:0] PH_DELTA     = 4'd2;
    localparam logic [3:0] PH_STATUS    = 4'd3;
    localparam logic [3:0] PH_CHDATA    = 4'd4;
    localparam logic [3:0] PH_META_TYPE = 4'd5;
    localparam logic [3:0] PH_META_LEN  = 4'd6;
    localparam logic [3:0] PH_META_BODY = 4'd7;
    localparam logic [3:0] PH_SYSEX     = 4'd8;
    localparam logic [3:0] PH_SKIP      = 4'd9;
    localparam logic [3:0] PH_STOPPED   = 4'd10;

    localparam logic [7:0] ST_META   = 8'hFF;
    localparam logic [7:0] ST_SYSEX  = 8'hF0;
    localparam logic [7:0] ST_EOX    = 8'hF7;
    localparam logic [7:0] ST_SONG_P = 8'hF2;
    localparam logic [7:0] ST_SONG_S = 8'hF3;
    localparam logic [7:0] META_EOT  = 8'h2F;
    localparam logic [7:0] META_TMP  = 8'h51;
    localparam logic [3:0] CH_NOFF   = 4'h8;
    localparam logic [3:0] CH_NON    = 4'h9;
    localparam logic [3:0] CH_PROG   = 4'hC;
    localparam logic [3:0] CH_PRESS  = 4'hD;

    logic [3:0]     phase_reg, phase_next;
    logic [7:0]     rs_reg, rs_next;
    logic [2:0]     cnt_reg, cnt_next;
    logic [VLW-1:0] vl_reg, vl_next;
    logic [VLW-1:0] skip_reg, skip_next;
    logic [31:0]    tick_reg, tick_next;
    logic [7:0]     meta_reg, meta_next;
    logic [6:0]     first_reg, first_next;
    logic [23:0]    tempo_reg, tempo_next;

    logic [7:0]     b;
    logic [6:0]     d;
    logic [VLW-1:0] vl_base, vl_acc;
    logic [2:0]     cnt_base, vl_cnt;
    logic           vl_done;
    logic           fin;
    logic           chd;
    logic [2:0]     chd_cnt;
    logic [3:0]     ch_type;
    logic           two_data;

    always_comb
    begin
        b = beat.data_byte;
        d = beat.data_byte[6:0];

        phase_next = phase_reg;
        rs_next    = rs_reg;
        cnt_next   = cnt_reg;
        vl_next    = vl_reg;
        skip_next  = skip_reg;
        tick_next  = tick_reg;
        meta_next  = meta_reg;
        first_next = first_reg;
        tempo_next = tempo_reg;
        fin        = 1'b0;
        chd        = 1'b0;
        chd_cnt    = cnt_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (beat.start_track)
        begin
            phase_next = PH_HDR_TAG;
            cnt_next   = 3'd0;
            tick_next  = 32'd0;
            rs_next    = 8'd0;
        end

        // varlen shift; a header mismatch restarts the quantity from zero
        if (phase_next == PH_HDR_TAG)
        begin
            vl_base  = '0;
            cnt_base = 3'd0;
        end
        else
        begin
            vl_base  = vl_reg;
            cnt_base = cnt_next;
        end
        vl_acc  = (vl_base << 7) | VLW'(d);
        vl_cnt  = cnt_base + 3'd1;
        vl_done = !b[7] || (vl_cnt >= VL_MAX);

        ch_type  = rs_next[7:4];
        two_data = !(ch_type == CH_PROG || ch_type == CH_PRESS);

        unique case (phase_next)
            PH_HDR_TAG:
            begin
                if (cnt_next < 3'd4 && b == mtep_pkg::tag_byte(cnt_next[1:0]))
                begin
                    if (cnt_next == 3'd3)
                    begin
                        cnt_next   = 3'd0;
                        phase_next = PH_HDR_LEN;
                    end
                    else
                    begin
                        cnt_next = cnt_next + 3'd1;
                    end
                end
                else
                begin
                    phase_next = PH_DELTA;
                    vl_next    = vl_acc;
                    cnt_next   = vl_cnt;
                    if (vl_done)
                    begin
                        tick_next  = tick_next + 32'(vl_acc);
                        phase_next = PH_STATUS;
                    end
                end
            end
            PH_HDR_LEN:
            begin
                cnt_next = cnt_next + 3'd1;
                if (cnt_next >= 3'd4)
                begin
                    phase_next = PH_DELTA;
                    cnt_next   = 3'd0;
                    vl_next    = '0;
                end
            end
            PH_DELTA:
            begin
                vl_next  = vl_acc;
                cnt_next = vl_cnt;
                if (vl_done)
                begin
                    tick_next  = tick_next + 32'(vl_acc);
                    phase_next = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                if (!b[7])
                begin
                    chd     = 1'b1;
                    chd_cnt = 3'd0;
                end
                else if (b < ST_SYSEX)
                begin
                    rs_next    = b;
                    cnt_next   = 3'd0;
                    phase_next = PH_CHDATA;
                end
                else
                begin
                    rs_next = 8'd0;
                    priority if (b == ST_META)
                    begin
                        phase_next = PH_META_TYPE;
                    end
                    else if (b == ST_SYSEX)
                    begin
                        phase_next = PH_SYSEX;
                    end
                    else if (b == ST_SONG_P || b == ST_SONG_S)
                    begin
                        skip_next  = (b == ST_SONG_P) ? VLW'(2) : VLW'(1);
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_DELTA;
                        cnt_next   = 3'd0;
                        vl_next    = '0;
                    end
                end
            end
            PH_CHDATA:
            begin
                chd     = 1'b1;
                chd_cnt = cnt_next;
            end
            PH_META_TYPE:
            begin
                meta_next  = b;
                cnt_next   = 3'd0;
                vl_next    = '0;
                phase_next = PH_META_LEN;
            end
            PH_META_LEN:
            begin
                vl_next  = vl_acc;
                cnt_next = vl_cnt;
                if (vl_done)
                begin
                    skip_next  = vl_acc;
                    cnt_next   = 3'd0;
                    tempo_next = 24'd0;
                    if (vl_acc == '0)
                        fin = 1'b1;
                    else
                        phase_next = PH_META_BODY;
                end
            end
            PH_META_BODY:
            begin
                if (meta_next == META_TMP && cnt_next < 3'd3)
                begin
                    tempo_next = {tempo_next[15:0], b};
                    cnt_next   = cnt_next + 3'd1;
                end
                skip_next = skip_next - VLW'(1);
                if (skip_next == '0)
                    fin = 1'b1;
            end
            PH_SYSEX:
            begin
                if (b == ST_EOX)
                begin
                    phase_next = PH_DELTA;
                    cnt_next   = 3'd0;
                    vl_next    = '0;
                end
            end
            PH_SKIP:
            begin
                if (skip_next <= VLW'(1))
                begin
                    phase_next = PH_DELTA;
                    cnt_next   = 3'd0;
                    vl_next    = '0;
                end
                else
                begin
                    skip_next = skip_next - VLW'(1);
                end
            end
            default:
            begin
                phase_next = PH_STOPPED;
            end
        endcase

        // one data byte of a channel message
        if (chd)
        begin
            if (chd_cnt == 3'd0 && two_data)
            begin
                first_next = d;
                cnt_next   = 3'd1;
                phase_next = PH_CHDATA;
            end
            else
            begin
                phase_next = PH_DELTA;
                cnt_next   = 3'd0;
                vl_next    = '0;
                if (ch_type == CH_NOFF || ch_type == CH_NON)
                begin
                    res_valid      = 1'b1;
                    res.event_kind = (ch_type == CH_NON) ? mtep_pkg::KIND_NOTE_ON
                                                         : mtep_pkg::KIND_NOTE_OFF;
                    res.channel    = rs_next[3:0];
                    res.note_key   = first_reg;
                    res.velocity   = d;
                end
            end
        end

        // end of a meta event body
        if (fin)
        begin
            if (meta_next == META_EOT)
            begin
                res_valid      = 1'b1;
                res.event_kind = mtep_pkg::KIND_END_TRACK;
                rs_next        = 8'd0;
                cnt_next       = 3'd0;
                phase_next     = header_after_end ? PH_HDR_TAG : PH_STOPPED;
            end
            else
            begin
                phase_next = PH_DELTA;
                cnt_next   = 3'd0;
                vl_next    = '0;
                if (meta_next == META_TMP)
                begin
                    res_valid        = 1'b1;
                    res.event_kind   = mtep_pkg::KIND_SET_TEMPO;
                    res.tempo_micros = tempo_next;
                end
            end
        end

        res.event_tick = tick_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR_TAG;
            rs_reg    <= 8'd0;
            cnt_reg   <= 3'd0;
            vl_reg    <= '0;
            skip_reg  <= '0;
            tick_reg  <= 32'd0;
            meta_reg  <= 8'd0;
            first_reg <= 7'd0;
            tempo_reg <= 24'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            rs_reg    <= rs_next;
            cnt_reg   <= cnt_next;
            vl_reg    <= vl_next;
            skip_reg  <= skip_next;
            tick_reg  <= tick_next;
            meta_reg  <= meta_next;
            first_reg <= first_next;
            tempo_reg <= tempo_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mtep_out_buf.sv =====
// mtep_out_buf: two-entry result buffer that registers the event channel.
// Depends on mtep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtep_out_buf (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire mtep_pkg::evt_beat_t push_data,
    output logic                     has_room,
    output logic                     evt_valid,
    input  wire logic                evt_stall,
    output mtep_pkg::evt_beat_t      evt_beat
);

    mtep_pkg::evt_beat_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign evt_valid = (count_reg != 2'd0);
    assign evt_beat  = slot_reg[rd_ptr_reg];
    assign has_room  = (count_reg != 2'd2);
    assign pop       = evt_valid && !evt_stall;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== sv/midi_track_event_parser.sv =====
// midi_track_event_parser: top level with input register, config register,
// parser core and result buffer. Depends on mtep_pkg, mtep_core, mtep_out_buf.
//
//   channel   direction  handshake              payload
//   trk       in         trk_valid / trk_stall  trk_beat  (one track byte)
//   evt       out        evt_valid / evt_stall  evt_beat  (one parsed event)
//   config    in         apb psel/penable       header_after_end at 0x0
//
// one byte is taken every cycle unless trk_stall is high; after its byte is
// accepted an event passes the input register, then the result buffer
// the per-byte phase update in mtep_core sets the cycle budget
// trk_stall rises only while the two-entry result buffer is full
// reset leaves the parser waiting for a chunk header, header_after_end = 1
`timescale 1ns / 1ps
`default_nettype none

module midi_track_event_parser #(
    parameter int MAX_VARLEN_BYTES = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                trk_valid,
    output logic                     trk_stall,
    input  wire mtep_pkg::trk_beat_t trk_beat,
    output logic                     evt_valid,
    input  wire logic                evt_stall,
    output mtep_pkg::evt_beat_t      evt_beat,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic                hae_reg;
    logic                in_valid_reg, in_valid_next;
    mtep_pkg::trk_beat_t in_beat_reg;
    logic                has_room;
    logic                step;
    logic                take;
    logic                res_valid;
    mtep_pkg::evt_beat_t res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == mtep_pkg::REG_HEADER_AFTER_END) ? {31'd0, hae_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hae_reg <= 1'b1;
        else if (psel && penable && pwrite && paddr[2] == mtep_pkg::REG_HEADER_AFTER_END)
            hae_reg <= pwdata[0];
    end

    // the held beat moves into the core whenever the result buffer has room
    assign step      = in_valid_reg && has_room;
    assign trk_stall = in_valid_reg && !has_room;
    assign take      = trk_valid && !trk_stall;

    always_comb
    begin
        in_valid_next = take || (in_valid_reg && !step);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_beat_reg <= trk_beat;
    end

    mtep_core #(
        .MAX_VARLEN_BYTES (MAX_VARLEN_BYTES)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .beat             (in_beat_reg),
        .header_after_end (hae_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    mtep_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && res_valid),
        .push_data (res),
        .has_room  (has_room),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_beat  (evt_beat)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// tb: self-checking bench for midi_track_event_parser, driving track bytes and
// checking parsed events against an in-bench parser model.
// Depends on mtep_pkg and midi_track_event_parser.
`timescale 1ns / 1ps

module tb;

    localparam int     MAX_VLQ_BYTES   = 4;
    localparam int     ITEMS_PER_PHASE = 175;
    localparam int     HOLD_CYCLES     = 300;
    localparam int     SETTLE_CYCLES   = 8;
    localparam int     DRAIN_LIMIT     = 200000;
    localparam int     MAX_PRINTS      = 40;
    localparam longint RUN_LIMIT_NS    = 1000000;

    localparam logic [2:0]  HDR_CFG_ADDR = 3'(mtep_pkg::REG_HEADER_AFTER_END) * 3'd4;
    localparam logic [31:0] MTRK_TAG     = 32'h4D54726B;

    localparam logic [7:0] ST_META      = 8'hFF;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END = 8'hF7;
    localparam logic [7:0] ST_SONG_POS  = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_PROGRAM  = 4'hC;
    localparam logic [3:0] NIB_CH_PRESS = 4'hD;
    localparam logic [3:0] NIB_POLY_AT  = 4'hA;

    typedef enum logic [3:0] {
        P_TAG, P_TAGLEN, P_DELTA, P_STATUS, P_CHDATA, P_MTYPE,
        P_MLEN, P_MBODY, P_SYSEX, P_SKIP, P_STOPPED
    } parse_ph_e;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                trk_valid = 1'b0;
    logic                trk_stall;
    mtep_pkg::trk_beat_t trk_beat  = '0;
    logic                evt_valid;
    logic                evt_stall = 1'b0;
    mtep_pkg::evt_beat_t evt_beat;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [2:0]          paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;

    midi_track_event_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .trk_valid (trk_valid),
        .trk_stall (trk_stall),
        .trk_beat  (trk_beat),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_beat  (evt_beat),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // ---------------- parser model ----------------
    parse_ph_e           pp;
    logic [7:0]          held_status;
    logic [2:0]          cnt;
    logic [27:0]         vlq;
    logic [27:0]         skip_left;
    logic [31:0]         tick;
    logic [7:0]          meta_type;
    logic [6:0]          data0;
    logic [23:0]         tempo_acc;
    logic                hdr_again;
    bit                  event_due;
    mtep_pkg::evt_beat_t next_event;

    function automatic void clear_parser();
        pp          = P_TAG;
        held_status = '0;
        cnt         = '0;
        vlq         = '0;
        skip_left   = '0;
        tick        = '0;
        meta_type   = '0;
        data0       = '0;
        tempo_acc   = '0;
        hdr_again   = 1'b1;
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [3:0] ch,
                                 input logic [6:0] key, input logic [6:0] vel,
                                 input logic [23:0] tempo);
        event_due               = 1'b1;
        next_event.event_kind   = kind;
        next_event.channel      = ch;
        next_event.note_key     = key;
        next_event.velocity     = vel;
        next_event.tempo_micros = tempo;
        next_event.event_tick   = tick;
    endfunction

    function automatic void to_delta();
        pp  = P_DELTA;
        cnt = '0;
        vlq = '0;
    endfunction

    function automatic bit vlq_shift(input logic [7:0] b);
        vlq = {vlq[20:0], b[6:0]};
        cnt = cnt + 3'd1;
        return !b[7] || (int'(cnt) >= MAX_VLQ_BYTES);
    endfunction

    function automatic void end_meta();
        if (meta_type == META_EOT)
        begin
            emit(mtep_pkg::KIND_END_TRACK, '0, '0, '0, '0);
            held_status = '0;
            cnt         = '0;
            pp          = hdr_again ? P_TAG : P_STOPPED;
            return;
        end
        to_delta();
        if (meta_type == META_TEMPO)
            emit(mtep_pkg::KIND_SET_TEMPO, '0, '0, '0, tempo_acc);
    endfunction

    function automatic void chan_data(input logic [7:0] b);
        logic [3:0] hi;
        bit         one_byte;
        hi       = held_status[7:4];
        one_byte = (hi == NIB_PROGRAM) || (hi == NIB_CH_PRESS);
        if (cnt == 0 && !one_byte)
        begin
            data0 = b[6:0];
            cnt   = 3'd1;
            pp    = P_CHDATA;
            return;
        end
        to_delta();
        if (hi == NIB_NOTE_OFF || hi == NIB_NOTE_ON)
            emit((hi == NIB_NOTE_ON) ? mtep_pkg::KIND_NOTE_ON : mtep_pkg::KIND_NOTE_OFF,
                 held_status[3:0], data0, b[6:0], '0);
    endfunction

    function automatic void status_in(input logic [7:0] b);
        if (!b[7])
        begin
            cnt = '0;
            chan_data(b);
            return;
        end
        if (b < ST_SYSEX)
        begin
            held_status = b;
            cnt         = '0;
            pp          = P_CHDATA;
            return;
        end
        held_status = '0;
        if (b == ST_META)
            pp = P_MTYPE;
        else if (b == ST_SYSEX)
            pp = P_SYSEX;
        else if (b == ST_SONG_POS || b == ST_SONG_SEL)
        begin
            skip_left = (b == ST_SONG_POS) ? 28'd2 : 28'd1;
            pp        = P_SKIP;
        end
        else
            to_delta();
    endfunction

    function automatic void parse_byte(input mtep_pkg::trk_beat_t bt);
        logic [7:0] b;
        b         = bt.data_byte;
        event_due = 1'b0;
        if (bt.start_track)
        begin
            pp          = P_TAG;
            cnt         = '0;
            tick        = '0;
            held_status = '0;
        end
        case (pp)
            P_TAG:
            begin
                if (cnt < 3'd4 && b == MTRK_TAG[8 * (3 - int'(cnt)) +: 8])
                begin
                    cnt = cnt + 3'd1;
                    if (cnt >= 3'd4)
                    begin
                        cnt = '0;
                        pp  = P_TAGLEN;
                    end
                end
                else
                begin
                    // broken tag: this byte opens the first delta time
                    to_delta();
                    if (vlq_shift(b))
                    begin
                        tick = tick + 32'(vlq);
                        pp   = P_STATUS;
                    end
                end
            end
            P_TAGLEN:
            begin
                cnt = cnt + 3'd1;
                if (cnt >= 3'd4)
                    to_delta();
            end
            P_DELTA:
            begin
                if (vlq_shift(b))
                begin
                    tick = tick + 32'(vlq);
                    pp   = P_STATUS;
                end
            end
            P_STATUS: status_in(b);
            P_CHDATA: chan_data(b);
            P_MTYPE:
            begin
                meta_type = b;
                cnt       = '0;
                vlq       = '0;
                pp        = P_MLEN;
            end
            P_MLEN:
            begin
                if (vlq_shift(b))
                begin
                    skip_left = vlq;
                    cnt       = '0;
                    tempo_acc = '0;
                    if (skip_left == 0)
                        end_meta();
                    else
                        pp = P_MBODY;
                end
            end
            P_MBODY:
            begin
                if (meta_type == META_TEMPO && cnt < 3'd3)
                begin
                    tempo_acc = {tempo_acc[15:0], b};
                    cnt       = cnt + 3'd1;
                end
                skip_left = skip_left - 28'd1;
                if (skip_left == 0)
                    end_meta();
            end
            P_SYSEX:
            begin
                if (b == ST_SYSEX_END)
                    to_delta();
            end
            P_SKIP:
            begin
                if (skip_left <= 28'd1)
                    to_delta();
                else
                    skip_left = skip_left - 28'd1;
            end
            default: pp = P_STOPPED;
        endcase
    endfunction

    // ---------------- checking ----------------
    mtep_pkg::evt_beat_t expected_events[$];
    int                  mismatches = 0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic check_event(input mtep_pkg::evt_beat_t got,
                               input mtep_pkg::evt_beat_t want);
        if (got.event_kind !== want.event_kind)
            report_mismatch($sformatf("event_kind got %0d want %0d",
                                      got.event_kind, want.event_kind));
        if (got.channel !== want.channel)
            report_mismatch($sformatf("channel got %0d want %0d", got.channel, want.channel));
        if (got.note_key !== want.note_key)
            report_mismatch($sformatf("note_key got %0d want %0d",
                                      got.note_key, want.note_key));
        if (got.velocity !== want.velocity)
            report_mismatch($sformatf("velocity got %0d want %0d",
                                      got.velocity, want.velocity));
        if (got.tempo_micros !== want.tempo_micros)
            report_mismatch($sformatf("tempo_micros got %h want %h",
                                      got.tempo_micros, want.tempo_micros));
        if (got.event_tick !== want.event_tick)
            report_mismatch($sformatf("event_tick got %h want %h",
                                      got.event_tick, want.event_tick));
    endtask

    logic trk_took = 1'b0;

    always @(posedge clk)
    begin : monitor
        mtep_pkg::evt_beat_t want;
        if (!rst_n)
            trk_took <= 1'b0;
        else
        begin
            trk_took <= trk_valid && !trk_stall;
            if (trk_valid && !trk_stall)
            begin
                parse_byte(trk_beat);
                if (event_due)
                    expected_events.push_back(next_event);
            end
            if (evt_valid && !evt_stall)
            begin
                if (expected_events.size() == 0)
                    report_mismatch($sformatf("unexpected event kind %0d tick %h",
                                              evt_beat.event_kind, evt_beat.event_tick));
                else
                begin
                    want = expected_events.pop_front();
                    check_event(evt_beat, want);
                end
            end
        end
    end

    // ---------------- driver and receiver ----------------
    mtep_pkg::trk_beat_t trk_pending[$];
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    bit                  pressure_on    = 1'b0;
    bit                  pressure_done  = 1'b0;
    int                  hold_count     = 0;

    always @(negedge clk)
    begin
        // a beat that was offered but not taken stays put
        if (rst_n && !(trk_valid && !trk_took))
        begin
            if (trk_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                trk_valid <= 1'b1;
                trk_beat  <= trk_pending.pop_front();
            end
            else
                trk_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (pressure_on && !pressure_done)
        begin
            evt_stall  <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count >= HOLD_CYCLES - 1)
                pressure_done <= 1'b1;
        end
        else
            evt_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // ---------------- config port ----------------
    task automatic apb_write(input logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = HDR_CFG_ADDR;
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        hdr_again = val[0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_check_read();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = HDR_CFG_ADDR;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== 32'(hdr_again))
            report_mismatch($sformatf("header_after_end read %h want %0d", prdata, hdr_again));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // ---------------- stream generation ----------------
    bit         start_next  = 1'b0;
    bit         need_start  = 1'b0;
    logic [7:0] gen_status  = '0;
    int         phase_items = 0;

    task automatic push_beat(input logic [7:0] b, input bit counted);
        mtep_pkg::trk_beat_t bt;
        bt.data_byte   = b;
        bt.start_track = start_next;
        start_next     = 1'b0;
        trk_pending.push_back(bt);
        if (counted)
            phase_items++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_beat(b, 1'b1);
    endtask

    function automatic logic [7:0] rand_data();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic put_varlen(input logic [27:0] v, input int nb, input bit overlong);
        for (int i = nb - 1; i >= 0; i--)
            push_byte({(i != 0) || overlong, v[7 * i +: 7]});
    endtask

    task automatic put_delta();
        int          r;
        int          nb;
        logic [27:0] v;
        r  = $urandom_range(0, 15);
        nb = (r < 8) ? 1 : (r < 12) ? 2 : (r < 14) ? 3 : 4;
        v  = 28'($urandom);
        if (nb < 4)
            v = v & ((28'd1 << (7 * nb)) - 28'd1);
        else if ($urandom_range(0, 3) == 0)
            v = '1;
        // padded encoding with a leading zero group
        if (nb < 4 && $urandom_range(0, 7) == 0)
            nb++;
        put_varlen(v, nb, (nb == 4) && ($urandom_range(0, 7) == 0));
    endtask

    task automatic put_event(input bit with_delta);
        int         r;
        int         n;
        int         k;
        logic [7:0] b;
        if (with_delta)
            put_delta();
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            if (!(gen_status[7:5] == 3'b100 && $urandom_range(0, 1) == 1))
            begin
                gen_status = {3'b100, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15))};
                push_byte(gen_status);
            end
            push_byte(rand_data());
            push_byte(rand_data());
        end
        else if (r < 60)
        begin
            gen_status = {NIB_POLY_AT + 4'($urandom_range(0, 4)), 4'($urandom_range(0, 15))};
            push_byte(gen_status);
            n = (gen_status[7:4] == NIB_PROGRAM || gen_status[7:4] == NIB_CH_PRESS) ? 1 : 2;
            repeat (n) push_byte(rand_data());
        end
        else if (r < 68)
        begin
            gen_status = '0;
            push_byte(ST_META);
            push_byte(META_TEMPO);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 3;
            put_varlen(28'(n), 1, 1'b0);
            repeat (n) push_byte(8'($urandom_range(0, 255)));
        end
        else if (r < 75)
        begin
            gen_status = '0;
            push_byte(ST_META);
            do b = 8'($urandom_range(0, 255)); while (b == META_EOT || b == META_TEMPO);
            push_byte(b);
            n = $urandom_range(0, 6);
            k = $urandom_range(0, 15);
            if (k == 0)
                put_varlen(28'(n), 4, 1'b1);
            else
                put_varlen(28'(n), (k < 4) ? 2 : 1, 1'b0);
            repeat (n) push_byte(8'($urandom_range(0, 255)));
        end
        else if (r < 81)
        begin
            gen_status = '0;
            push_byte(ST_SYSEX);
            repeat ($urandom_range(0, 5))
            begin
                do b = 8'($urandom_range(0, 255)); while (b == ST_SYSEX_END);
                push_byte(b);
            end
            push_byte(ST_SYSEX_END);
        end
        else if (r < 87)
        begin
            gen_status = '0;
            if ($urandom_range(0, 1) == 1)
            begin
                push_byte(ST_SONG_POS);
                repeat (2) push_byte(rand_data());
            end
            else
            begin
                push_byte(ST_SONG_SEL);
                push_byte(rand_data());
            end
        end
        else if (r < 91)
        begin
            gen_status = '0;
            do b = 8'($urandom_range(8'hF1, 8'hFE));
            while (b == ST_SONG_POS || b == ST_SONG_SEL);
            push_byte(b);
        end
        else
        begin
            // data byte in status position: running status, or an unknown message
            push_byte(8'($urandom_range(0, 127)));
            n = (gen_status[7:4] == NIB_PROGRAM || gen_status[7:4] == NIB_CH_PRESS) ? 0 : 1;
            repeat (n) push_byte(rand_data());
        end
    endtask

    task automatic put_track();
        int h;
        int n;
        if (need_start || $urandom_range(0, 7) == 0)
        begin
            start_next = 1'b1;
            gen_status = '0;
        end
        need_start = 1'b0;
        h = $urandom_range(0, 7);
        if (h < 5)
        begin
            for (int i = 0; i < 4; i++)
                push_byte(MTRK_TAG[8 * (3 - i) +: 8]);
            repeat (4) push_byte(8'($urandom_range(0, 255)));
            put_event(1'b1);
        end
        else if (h == 5)
        begin
            // tag cut short; the zero byte is taken as the delta time
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                push_byte(MTRK_TAG[8 * (3 - i) +: 8]);
            push_byte(8'h00);
            put_event(1'b0);
        end
        else
            put_event(1'b1);
        repeat ($urandom_range(0, 11)) put_event(1'b1);
        put_delta();
        push_byte(ST_META);
        push_byte(META_EOT);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        put_varlen(28'(n), 1, 1'b0);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
        gen_status = '0;
        if (!hdr_again)
        begin
            repeat ($urandom_range(0, 3)) push_beat(8'($urandom_range(0, 255)), 1'b0);
            need_start = 1'b1;
        end
    endtask

    task automatic put_noise();
        repeat ($urandom_range(4, 16))
        begin
            if ($urandom_range(0, 15) == 0)
                start_next = 1'b1;
            push_byte(8'($urandom_range(0, 255)));
        end
        need_start = 1'b1;
        gen_status = '0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while ((trk_pending.size() != 0 || trk_valid || expected_events.size() != 0)
               && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int mode;
        clear_parser();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        apb_check_read();

        // directed: header, longest delta, note on with zero velocity on channel 15,
        // note off with bit seven set in its data, largest tempo, end of track
        for (int i = 0; i < 4; i++)
            push_byte(MTRK_TAG[8 * (3 - i) +: 8]);
        push_byte(8'h00); push_byte(8'h00); push_byte(8'h00); push_byte(8'h1A);
        repeat (4) push_byte(8'hFF);
        push_byte(8'h9F); push_byte(8'h00); push_byte(8'h00);
        push_byte(8'h00); push_byte(8'h80); push_byte(8'hFF); push_byte(8'hFF);
        push_byte(8'h00); push_byte(ST_META); push_byte(META_TEMPO); push_byte(8'h03);
        repeat (3) push_byte(8'hFF);
        push_byte(8'h00); push_byte(ST_META); push_byte(META_EOT); push_byte(8'h00);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            mode = p / 2;
            apb_write(32'(p % 2));
            apb_check_read();
            send_idle_pct  = (mode == 1) ? 56 : (mode == 3) ? 37 : 0;
            recv_stall_pct = (mode == 2) ? 56 : (mode == 3) ? 37 : 0;
            if (p == 0)
                pressure_on = 1'b1;
            need_start  = 1'b1;
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) == 0)
                    put_noise();
                else
                    put_track();
            end
            drain();
        end

        if (expected_events.size() != 0)
            report_mismatch($sformatf("%0d events never arrived", expected_events.size()));
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
